@@ sv/lssa_pkg.sv @@
// shared constants, types and tables of the led strip snake animator
// no dependencies

package lssa_pkg;

    localparam int NUM_SNAKES = 10;
    localparam int NUM_PIXELS = 200;

    localparam int CMD_W      = 2;
    localparam int PIX_W      = 10;
    localparam int HUE_W      = 8;
    localparam int STEP_W     = 16;
    localparam int CNT_W      = 16;
    localparam int LEN_W      = 4;
    localparam int LVL_W      = 8;
    localparam int IDX_W      = 3;
    localparam int CFG_DATA_W = 16;
    localparam int MAX_TRAIL  = 15;

    localparam int BSUM_W = $clog2(NUM_SNAKES * 255 + 1);
    localparam int HSUM_W = $clog2(NUM_SNAKES * 65025 + 1);
    localparam int OVL_W  = $clog2(NUM_SNAKES + 1);

    localparam logic [IDX_W-1:0] REG_INTERVAL = 3'd0;
    localparam logic [IDX_W-1:0] REG_TRAIL    = 3'd1;
    localparam logic [IDX_W-1:0] REG_FMIN     = 3'd2;
    localparam logic [IDX_W-1:0] REG_FMAX     = 3'd3;
    localparam logic [IDX_W-1:0] REG_HSTEP    = 3'd4;
    localparam logic [IDX_W-1:0] REG_SAT      = 3'd5;

    localparam logic [CNT_W-1:0] RST_INTERVAL = 16'd50;
    localparam logic [LEN_W-1:0] RST_TRAIL    = 4'd5;
    localparam logic [LVL_W-1:0] RST_FMIN     = 8'd50;
    localparam logic [LVL_W-1:0] RST_FMAX     = 8'd255;
    localparam logic [LVL_W-1:0] RST_HSTEP    = 8'd30;
    localparam logic [LVL_W-1:0] RST_SAT      = 8'd230;

    // round(num / 65025) half up as floor((2 num + 65025) * RND_MUL >> RND_SHIFT)
    localparam logic [25:0] RND_BIAS  = 26'd65025;
    localparam logic [25:0] RND_MUL   = 26'd33818121;
    localparam int          RND_SHIFT = 42;

    typedef enum logic [CMD_W-1:0] {
        CMD_SPAWN = 2'd0,
        CMD_TICK  = 2'd1,
        CMD_QUERY = 2'd2,
        CMD_NONE  = 2'd3
    } t_cmd;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_CHAIN,
        ST_DIV,
        ST_HUE,
        ST_HSV1,
        ST_HSV2,
        ST_HSV3,
        ST_RND,
        ST_DONE
    } t_state;

    typedef enum logic [2:0] {
        SEC_RY,
        SEC_YG,
        SEC_GC,
        SEC_CB,
        SEC_BM,
        SEC_MR
    } t_sector;

    typedef logic [MAX_TRAIL-1:0][LVL_W-1:0] t_btab;

    typedef struct packed {
        t_cmd                    cmd;
        logic [PIX_W-1:0]        pixel;
        logic [HUE_W-1:0]        hue;
        logic [LEN_W-1:0]        len;
        logic [CNT_W-1:0]        interval;
        t_btab                   btab;
    } t_cell_ctl;

    typedef struct packed {
        logic                    go;
        logic                    free;
        logic [BSUM_W-1:0]       bsum;
        logic [HSUM_W-1:0]       hsum;
        logic [OVL_W-1:0]        ovl;
    } t_link;

    // ceil(65536 / m) for m of 1 to 14 (65536 otherwise), exact quotient for numerators below 4096
    function automatic logic [16:0] f_recip(input logic [LEN_W-1:0] m);
        logic [16:0] r;
        case (m)
            4'd2:    r = 17'd32768;
            4'd3:    r = 17'd21846;
            4'd4:    r = 17'd16384;
            4'd5:    r = 17'd13108;
            4'd6:    r = 17'd10923;
            4'd7:    r = 17'd9363;
            4'd8:    r = 17'd8192;
            4'd9:    r = 17'd7282;
            4'd10:   r = 17'd6554;
            4'd11:   r = 17'd5958;
            4'd12:   r = 17'd5462;
            4'd13:   r = 17'd5042;
            4'd14:   r = 17'd4682;
            default: r = 17'd65536;
        endcase
        return r;
    endfunction

endpackage

@@ sv/lssa_if.sv @@
// request channels of the led strip snake animator: input, result, register write
// depends on lssa_pkg

interface lssa_in_if;
    logic                         valid;
    logic                         ready;
    lssa_pkg::t_cmd               cmd;
    logic [lssa_pkg::PIX_W-1:0]   pixel;
    logic [lssa_pkg::HUE_W-1:0]   hue;
    modport source(output valid, cmd, pixel, hue, input ready);
    modport sink(input valid, cmd, pixel, hue, output ready);
endinterface

interface lssa_out_if;
    logic                         valid;
    logic                         ready;
    logic                         accepted;
    logic [lssa_pkg::LVL_W-1:0]   red;
    logic [lssa_pkg::LVL_W-1:0]   green;
    logic [lssa_pkg::LVL_W-1:0]   blue;
    modport source(output valid, accepted, red, green, blue, input ready);
    modport sink(input valid, accepted, red, green, blue, output ready);
endinterface

interface lssa_cfg_if;
    logic                              valid;
    logic                              ready;
    logic [lssa_pkg::IDX_W-1:0]        index;
    logic [lssa_pkg::CFG_DATA_W-1:0]   data;
    modport source(output valid, index, data, input ready);
    modport sink(input valid, index, data, output ready);
endinterface

@@ sv/led_strip_snake_animator_unit.sv @@
// top level of the led strip snake animator: registers, chain of snake cells,
// hue divider and hsv to rgb stages; depends on lssa_pkg, lssa_if, lssa_cell, lssa_div
//
// channel   dir  payload                          handshake
// i_in      in   cmd, pixel, hue                  valid / ready
// o_out     out  accepted, red, green, blue       valid / ready
// i_cfg     in   index, data                      valid / ready (ready always high)
//
// every request walks the cell chain, one cell per cycle
// a query with a lit pixel adds the divider and five color stages
// after reset and after a write of trail_length, fade_min or fade_max
// the brightness table is rebuilt, with i_in.ready low
// a waiting result in o_out does not hold i_in; only the next result waits for it

module led_strip_snake_animator_unit (
    input  logic        i_clk,
    input  logic        i_rst_n,
    lssa_in_if.sink     i_in,
    lssa_out_if.source  o_out,
    lssa_cfg_if.sink    i_cfg
);

    localparam int N = lssa_pkg::NUM_SNAKES;

    lssa_pkg::t_state r_state, n_state;

    logic [lssa_pkg::CNT_W-1:0] r_interval;
    logic [lssa_pkg::LEN_W-1:0] r_len;
    logic [lssa_pkg::LVL_W-1:0] r_fmin, r_fmax, r_hstep, r_sat;

    logic                       r_bfill;
    logic [3:0]                 r_bidx;
    logic [11:0]                r_bacc;
    lssa_pkg::t_btab            r_btab;

    lssa_pkg::t_cmd             r_cmd;
    logic [lssa_pkg::PIX_W-1:0] r_pix;
    logic [lssa_pkg::HUE_W-1:0] r_hue;
    logic                       r_go;

    logic                        r_acc;
    logic [lssa_pkg::BSUM_W-1:0] r_bsum;
    logic [lssa_pkg::OVL_W-1:0]  r_ovl;
    logic [7:0]                  r_hue8, r_val;
    logic [7:0]                  r_dist;
    lssa_pkg::t_sector           r_sec;
    logic [15:0]                 r_vs, r_vns;
    logic [23:0]                 r_cn, r_xn, r_mn;
    logic [24:0]                 r_nr, r_ng, r_nb;
    logic [7:0]                  r_cr, r_cg, r_cb;

    logic                        r_ovld;
    logic                        r_oacc;
    logic [7:0]                  r_ored, r_ogrn, r_oblu;

    logic                        w_in_rdy, w_accept, w_chain_end, w_lit, w_div_start;
    logic                        w_out_load, w_on_strip;
    logic                        w_div_done;
    logic [lssa_pkg::HSUM_W-1:0] w_quo;

    lssa_pkg::t_cell_ctl         w_ctl;
    lssa_pkg::t_link             w_link [N+1];
    logic [N:0]                  w_go_vec;

    logic [7:0]                  w_bdiff;
    logic [28:0]                 w_bprod;
    logic [8:0]                  w_bq, w_bup;
    logic [7:0]                  w_blvl;

    logic [lssa_pkg::OVL_W+7:0]  w_sprod;
    logic [10:0]                 w_h6;
    logic [8:0]                  w_hq;

    function automatic logic [7:0] f_round(input logic [24:0] num);
        logic [25:0] x;
        logic [51:0] p;
        logic [9:0]  v;
        x = {num, 1'b0} + lssa_pkg::RND_BIAS;
        p = 52'(x) * 52'(lssa_pkg::RND_MUL);
        v = p[51:lssa_pkg::RND_SHIFT];
        return (v > 10'd255) ? 8'd255 : v[7:0];
    endfunction

    // brightness table sweep
    assign w_bdiff = (r_fmax >= r_fmin) ? r_fmax - r_fmin : r_fmin - r_fmax;
    assign w_bprod = 29'(r_bacc) * 29'(lssa_pkg::f_recip(r_len - 1'b1));
    assign w_bq    = w_bprod[24:16];
    assign w_bup   = {1'b0, r_fmax} + w_bq;

    always_comb begin
        if ({1'b0, r_bidx} >= {1'b0, r_len}) begin
            w_blvl = '0;
        end else if (r_len == 4'd1) begin
            w_blvl = r_fmax;
        end else if (r_fmax >= r_fmin) begin
            w_blvl = r_fmax - w_bq[7:0];
        end else begin
            w_blvl = w_bup[8] ? 8'd255 : w_bup[7:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_interval <= lssa_pkg::RST_INTERVAL;
            r_len      <= lssa_pkg::RST_TRAIL;
            r_fmin     <= lssa_pkg::RST_FMIN;
            r_fmax     <= lssa_pkg::RST_FMAX;
            r_hstep    <= lssa_pkg::RST_HSTEP;
            r_sat      <= lssa_pkg::RST_SAT;
            r_bfill    <= 1'b1;
            r_bidx     <= '0;
            r_bacc     <= '0;
        end else begin
            if (r_bfill) begin
                r_btab[r_bidx] <= w_blvl;
                r_bacc         <= r_bacc + 12'(w_bdiff);
                r_bidx         <= r_bidx + 1'b1;
                if (r_bidx == 4'(lssa_pkg::MAX_TRAIL - 1)) begin
                    r_bfill <= 1'b0;
                end
            end
            if (i_cfg.valid && i_cfg.ready) begin
                case (i_cfg.index)
                    lssa_pkg::REG_INTERVAL: r_interval <= i_cfg.data;
                    lssa_pkg::REG_TRAIL:    r_len      <= i_cfg.data[3:0];
                    lssa_pkg::REG_FMIN:     r_fmin     <= i_cfg.data[7:0];
                    lssa_pkg::REG_FMAX:     r_fmax     <= i_cfg.data[7:0];
                    lssa_pkg::REG_HSTEP:    r_hstep    <= i_cfg.data[7:0];
                    lssa_pkg::REG_SAT:      r_sat      <= i_cfg.data[7:0];
                    default: ;
                endcase
                if (i_cfg.index == lssa_pkg::REG_TRAIL || i_cfg.index == lssa_pkg::REG_FMIN ||
                    i_cfg.index == lssa_pkg::REG_FMAX) begin
                    r_bfill <= 1'b1;
                    r_bidx  <= '0;
                    r_bacc  <= '0;
                end
            end
        end
    end

    assign i_cfg.ready = 1'b1;

    // cell chain
    assign w_ctl.cmd      = r_cmd;
    assign w_ctl.pixel    = r_pix;
    assign w_ctl.hue      = r_hue;
    assign w_ctl.len      = r_len;
    assign w_ctl.interval = r_interval;
    assign w_ctl.btab     = r_btab;

    assign w_on_strip = ({1'b0, r_pix} < 11'(lssa_pkg::NUM_PIXELS));

    assign w_link[0].go   = r_go;
    assign w_link[0].free = (r_cmd == lssa_pkg::CMD_SPAWN) && w_on_strip;
    assign w_link[0].bsum = '0;
    assign w_link[0].hsum = '0;
    assign w_link[0].ovl  = '0;
    assign w_go_vec[0]    = w_link[0].go;

    for (genvar g = 0; g < N; g++) begin : g_cell
        lssa_cell u_cell (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_ctl   (w_ctl),
            .i_link  (w_link[g]),
            .o_link  (w_link[g+1])
        );
        assign w_go_vec[g+1] = w_link[g+1].go;
    end

    lssa_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (w_div_start),
        .i_num   (w_link[N].hsum),
        .i_den   (w_link[N].bsum),
        .o_done  (w_div_done),
        .o_quo   (w_quo)
    );

    // next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            lssa_pkg::ST_IDLE:  if (w_accept) n_state = lssa_pkg::ST_CHAIN;
            lssa_pkg::ST_CHAIN: begin
                if (w_chain_end) begin
                    n_state = w_lit ? lssa_pkg::ST_DIV : lssa_pkg::ST_DONE;
                end
            end
            lssa_pkg::ST_DIV:   if (w_div_done) n_state = lssa_pkg::ST_HUE;
            lssa_pkg::ST_HUE:   n_state = lssa_pkg::ST_HSV1;
            lssa_pkg::ST_HSV1:  n_state = lssa_pkg::ST_HSV2;
            lssa_pkg::ST_HSV2:  n_state = lssa_pkg::ST_HSV3;
            lssa_pkg::ST_HSV3:  n_state = lssa_pkg::ST_RND;
            lssa_pkg::ST_RND:   n_state = lssa_pkg::ST_DONE;
            lssa_pkg::ST_DONE:  if (w_out_load) n_state = lssa_pkg::ST_IDLE;
            default:            n_state = lssa_pkg::ST_IDLE;
        endcase
    end

    // state outputs
    always_comb begin
        w_in_rdy    = (r_state == lssa_pkg::ST_IDLE) && !r_bfill;
        w_chain_end = (r_state == lssa_pkg::ST_CHAIN) && w_link[N].go;
        w_lit       = (r_cmd == lssa_pkg::CMD_QUERY) && w_on_strip && (w_link[N].bsum != '0);
        w_div_start = w_chain_end && w_lit;
        w_out_load  = (r_state == lssa_pkg::ST_DONE) && (!r_ovld || o_out.ready);
    end

    assign i_in.ready = w_in_rdy;
    assign w_accept   = i_in.valid && w_in_rdy;

    assign w_sprod = (r_ovl - 1'b1) * r_hstep;
    assign w_h6    = 11'(r_hue8) * 11'd6;
    assign w_hq    = (w_h6 >= 11'd1020) ? 9'(w_h6 - 11'd1020) :
                     (w_h6 >= 11'd510)  ? 9'(w_h6 - 11'd510)  : 9'(w_h6);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= lssa_pkg::ST_IDLE;
            r_go    <= 1'b0;
            r_ovld  <= 1'b0;
        end else begin
            r_state <= n_state;
            r_go    <= w_accept;
            if (w_accept) begin
                r_cmd <= i_in.cmd;
                r_pix <= i_in.pixel;
                r_hue <= i_in.hue;
            end
            if (w_chain_end) begin
                r_acc  <= (r_cmd == lssa_pkg::CMD_SPAWN) ? (w_on_strip && !w_link[N].free) :
                          (r_cmd == lssa_pkg::CMD_TICK || r_cmd == lssa_pkg::CMD_QUERY);
                r_bsum <= w_link[N].bsum;
                r_ovl  <= w_link[N].ovl;
                r_cr   <= '0;
                r_cg   <= '0;
                r_cb   <= '0;
            end
            if (r_state == lssa_pkg::ST_HUE) begin
                r_hue8 <= (r_ovl > lssa_pkg::OVL_W'(1)) ? w_quo[7:0] + w_sprod[7:0] : w_quo[7:0];
                r_val  <= (r_bsum > lssa_pkg::BSUM_W'(255)) ? 8'd255 : r_bsum[7:0];
            end
            if (r_state == lssa_pkg::ST_HSV1) begin
                r_dist <= (w_hq > 9'd255) ? 8'(w_hq - 9'd255) : 8'(9'd255 - w_hq);
                if (w_h6 < 11'd255)       r_sec <= lssa_pkg::SEC_RY;
                else if (w_h6 < 11'd510)  r_sec <= lssa_pkg::SEC_YG;
                else if (w_h6 < 11'd765)  r_sec <= lssa_pkg::SEC_GC;
                else if (w_h6 < 11'd1020) r_sec <= lssa_pkg::SEC_CB;
                else if (w_h6 < 11'd1275) r_sec <= lssa_pkg::SEC_BM;
                else                      r_sec <= lssa_pkg::SEC_MR;
                r_vs  <= r_val * r_sat;
                r_vns <= r_val * (8'd255 - r_sat);
            end
            if (r_state == lssa_pkg::ST_HSV2) begin
                r_cn <= {r_vs, 8'd0} - 24'(r_vs);
                r_xn <= 24'(r_vs) * 24'(8'd255 - r_dist);
                r_mn <= {r_vns, 8'd0} - 24'(r_vns);
            end
            if (r_state == lssa_pkg::ST_HSV3) begin
                case (r_sec)
                    lssa_pkg::SEC_RY: begin r_nr <= 25'(r_cn); r_ng <= 25'(r_xn); r_nb <= '0; end
                    lssa_pkg::SEC_YG: begin r_nr <= 25'(r_xn); r_ng <= 25'(r_cn); r_nb <= '0; end
                    lssa_pkg::SEC_GC: begin r_nr <= '0; r_ng <= 25'(r_cn); r_nb <= 25'(r_xn); end
                    lssa_pkg::SEC_CB: begin r_nr <= '0; r_ng <= 25'(r_xn); r_nb <= 25'(r_cn); end
                    lssa_pkg::SEC_BM: begin r_nr <= 25'(r_xn); r_ng <= '0; r_nb <= 25'(r_cn); end
                    default:          begin r_nr <= 25'(r_cn); r_ng <= '0; r_nb <= 25'(r_xn); end
                endcase
            end
            if (r_state == lssa_pkg::ST_RND) begin
                r_cr <= f_round(r_nr + 25'(r_mn));
                r_cg <= f_round(r_ng + 25'(r_mn));
                r_cb <= f_round(r_nb + 25'(r_mn));
            end
            if (w_out_load) begin
                r_ovld  <= 1'b1;
                r_oacc  <= r_acc;
                r_ored  <= r_cr;
                r_ogrn  <= r_cg;
                r_oblu  <= r_cb;
            end else if (o_out.ready) begin
                r_ovld <= 1'b0;
            end
        end
    end

    assign o_out.valid    = r_ovld;
    assign o_out.accepted = r_oacc;
    assign o_out.red      = r_ored;
    assign o_out.green    = r_ogrn;
    assign o_out.blue     = r_oblu;

`ifndef ASSERT_OFF
    a_accept_enters_chain: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in.valid && i_in.ready) |=> (r_state == lssa_pkg::ST_CHAIN))
        else $error("accepted request did not enter the chain");

    a_single_request: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $onehot0(w_go_vec))
        else $error("more than one request in the cell chain");

    a_chain_end_state: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_link[N].go |-> (r_state == lssa_pkg::ST_CHAIN))
        else $error("chain finished outside of the chain state");

    a_off_strip_dark: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == lssa_pkg::ST_DONE && !w_on_strip) |->
        (r_cr == '0 && r_cg == '0 && r_cb == '0))
        else $error("pixel off the strip has a color");
`endif

endmodule

@@ sv/lssa_cell.sv @@
// one snake slot of the chain: holds one snake, acts when the request passes
// depends on lssa_pkg

module lssa_cell (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  lssa_pkg::t_cell_ctl i_ctl,
    input  lssa_pkg::t_link     i_link,
    output lssa_pkg::t_link     o_link
);

    logic                           r_active;
    logic [lssa_pkg::PIX_W-1:0]     r_origin;
    logic [lssa_pkg::STEP_W-1:0]    r_step;
    logic [lssa_pkg::CNT_W-1:0]     r_count;
    logic [lssa_pkg::HUE_W-1:0]     r_hue;
    lssa_pkg::t_link                r_link;

    logic signed [18:0] w_o, w_p, w_k, w_len, w_diff;
    logic signed [18:0] w_dam, w_dap, w_dbm, w_dbp;
    logic               w_hit;
    logic [lssa_pkg::LVL_W-1:0] w_bb;
    logic               w_take;
    logic [lssa_pkg::CNT_W-1:0]  n_cnt;
    logic [lssa_pkg::STEP_W-1:0] n_step;
    logic signed [18:0] w_ks, w_om, w_op;
    logic               w_on;

    function automatic logic f_ok(input logic signed [18:0] d, input logic signed [18:0] len,
                                  input lssa_pkg::t_btab tab);
        logic ok;
        ok = (d >= 0) && (d < len);
        if (ok) begin
            ok = (tab[d[3:0]] != '0);
        end
        return ok;
    endfunction

    assign w_o    = $signed({9'd0, r_origin});
    assign w_p    = $signed({9'd0, i_ctl.pixel});
    assign w_k    = $signed({3'd0, r_step});
    assign w_len  = $signed({15'd0, i_ctl.len});
    assign w_diff = w_p - w_o;
    assign w_dam  = w_k - 19'sd1 + w_diff;
    assign w_dap  = w_k - 19'sd1 - w_diff;
    assign w_dbm  = w_k + w_diff;
    assign w_dbp  = w_k - w_diff;

    // coverage in order: previous step then current, minus side then plus
    always_comb begin
        w_hit = 1'b0;
        w_bb  = '0;
        if (r_step == '0 || (r_step == 16'd1 && w_diff == 19'sd0)) begin
            w_hit = (w_diff == 19'sd0);
            w_bb  = i_ctl.btab[0];
        end else if (r_step != 16'd1 && f_ok(w_dam, w_len, i_ctl.btab)) begin
            w_hit = 1'b1;
            w_bb  = i_ctl.btab[w_dam[3:0]];
        end else if (r_step != 16'd1 && f_ok(w_dap, w_len, i_ctl.btab)) begin
            w_hit = 1'b1;
            w_bb  = i_ctl.btab[w_dap[3:0]];
        end else if (f_ok(w_dbm, w_len, i_ctl.btab)) begin
            w_hit = 1'b1;
            w_bb  = i_ctl.btab[w_dbm[3:0]];
        end else if (f_ok(w_dbp, w_len, i_ctl.btab)) begin
            w_hit = 1'b1;
            w_bb  = i_ctl.btab[w_dbp[3:0]];
        end
    end

    // advance on tick and check that some trail pixel stays on the strip
    assign n_cnt  = (r_count != '1) ? r_count + 1'b1 : r_count;
    assign n_step = (r_step != '1) ? r_step + 1'b1 : r_step;
    assign w_ks   = $signed({3'd0, n_step});
    assign w_om   = w_o - w_ks;
    assign w_op   = w_o + w_ks;
    assign w_on   = (i_ctl.len != '0) &&
                    (((w_om + w_len - 19'sd1 >= 0) && (w_om <= 19'(lssa_pkg::NUM_PIXELS - 1))) ||
                     (w_op - w_len + 19'sd1 <= 19'(lssa_pkg::NUM_PIXELS - 1)));

    assign w_take = i_link.go && i_ctl.cmd == lssa_pkg::CMD_SPAWN && i_link.free && !r_active;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_active <= 1'b0;
            r_link   <= '0;
        end else begin
            r_link.go   <= i_link.go;
            r_link.free <= i_link.free && !w_take;
            r_link.bsum <= i_link.bsum;
            r_link.hsum <= i_link.hsum;
            r_link.ovl  <= i_link.ovl;
            if (w_take) begin
                r_active <= 1'b1;
                r_origin <= i_ctl.pixel;
                r_step   <= '0;
                r_count  <= '0;
                r_hue    <= i_ctl.hue;
            end
            if (i_link.go && i_ctl.cmd == lssa_pkg::CMD_TICK && r_active) begin
                if (n_cnt >= i_ctl.interval) begin
                    r_count  <= '0;
                    r_step   <= n_step;
                    r_active <= w_on;
                end else begin
                    r_count <= n_cnt;
                end
            end
            if (i_link.go && i_ctl.cmd == lssa_pkg::CMD_QUERY && r_active && w_hit) begin
                r_link.bsum <= i_link.bsum + lssa_pkg::BSUM_W'(w_bb);
                r_link.hsum <= i_link.hsum + lssa_pkg::HSUM_W'(r_hue * w_bb);
                r_link.ovl  <= i_link.ovl + 1'b1;
            end
        end
    end

    assign o_link = r_link;

endmodule

@@ sv/lssa_div.sv @@
// restoring divider for the weighted hue, one quotient bit per cycle
// depends on lssa_pkg

module lssa_div (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_start,
    input  logic [lssa_pkg::HSUM_W-1:0] i_num,
    input  logic [lssa_pkg::BSUM_W-1:0] i_den,
    output logic                        o_done,
    output logic [lssa_pkg::HSUM_W-1:0] o_quo
);

    localparam int CNT_W = $clog2(lssa_pkg::HSUM_W + 1);

    logic                         r_busy;
    logic                         r_done;
    logic [CNT_W-1:0]             r_cnt;
    logic [lssa_pkg::HSUM_W-1:0]  r_quo;
    logic [lssa_pkg::BSUM_W:0]    r_rem;
    logic [lssa_pkg::BSUM_W-1:0]  r_den;
    logic [lssa_pkg::BSUM_W:0]    w_sh;
    logic                         w_ge;

    assign w_sh = {r_rem[lssa_pkg::BSUM_W-1:0], r_quo[lssa_pkg::HSUM_W-1]};
    assign w_ge = (w_sh >= {1'b0, r_den});

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= CNT_W'(lssa_pkg::HSUM_W);
                r_quo  <= i_num;
                r_rem  <= '0;
                r_den  <= i_den;
            end else if (r_busy) begin
                r_rem <= w_ge ? w_sh - {1'b0, r_den} : w_sh;
                r_quo <= {r_quo[lssa_pkg::HSUM_W-2:0], w_ge};
                r_cnt <= r_cnt - 1'b1;
                if (r_cnt == CNT_W'(1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    assign o_done = r_done;
    assign o_quo  = r_quo;

endmodule
